>>> hw/rtl/bahc_pkg.sv
package bahc_pkg;

   // Conversion times in ticks.
   localparam logic [7:0] TEMP_TICKS  = 8'd2;
   localparam logic [7:0] PRESS_TICKS = 8'd8;

   // Conversion start codes on the result word.
   localparam logic [1:0] START_NONE  = 2'd0;
   localparam logic [1:0] START_TEMP  = 2'd1;
   localparam logic [1:0] START_PRESS = 2'd2;

   // Register map, indexed by paddr[4:2].
   localparam logic [2:0] REG_BARO_PRESENT = 3'd0;
   localparam logic [2:0] REG_TEMP_COEFF   = 3'd1;
   localparam logic [2:0] REG_PROP_GAIN    = 3'd2;
   localparam logic [2:0] REG_DIFF_GAIN    = 3'd3;
   localparam logic [2:0] REG_HARD_FILTER  = 3'd4;

   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   // Clamp limits of the hold loop.
   localparam logic signed [15:0] REL_MAX   = 16'sd8;
   localparam logic signed [15:0] REL_MIN   = -16'sd3;
   localparam logic signed [15:0] DELTA_MAX = 16'sd8;
   localparam logic signed [15:0] DELTA_MIN = -16'sd8;
   localparam logic signed [7:0]  DRIVE_MAX = 8'sd15;
   localparam logic signed [7:0]  DRIVE_MIN = -8'sd5;

   // Rounding of the temperature term before the divide by 32.
   localparam logic signed [15:0] COMP_ROUND = 16'sd16;
   localparam int                 COMP_SHIFT = 5;

   typedef struct packed {
      logic              baro_present;
      logic signed [7:0] temp_coeff;
      logic [6:0]        prop_gain;
      logic signed [7:0] diff_gain;
      logic              hard_filter;
   } cfg_type;

   typedef struct packed {
      logic load_in;
      logic eval;
      logic hold1;
      logic hold2;
      logic hold3;
      logic hold4;
      logic hold5;
      logic hold6;
      logic load_rsp;
   } cmd_type;

   typedef struct packed {
      logic hold_go;
   } sts_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_EVAL,
      ST_HOLD1,
      ST_HOLD2,
      ST_HOLD3,
      ST_HOLD4,
      ST_HOLD5,
      ST_HOLD6,
      ST_DONE
   } state_type;

endpackage

>>> hw/rtl/bahc_if.sv
interface bahc_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] sample;
   logic        read_ok;
   logic        start_ok;
   logic        throttle_moving;

   modport source (output valid, output sample, output read_ok, output start_ok,
                   output throttle_moving, input ready);
   modport sink (input valid, input sample, input read_ok, input start_ok,
                 input throttle_moving, output ready);
endinterface

interface bahc_rsp_if;
   logic              valid;
   logic              ready;
   logic signed [4:0] drive_correction;
   logic              sample_taken;
   logic [1:0]        start_request;
   logic              active;
   logic              hovering;
   logic signed [4:0] rel_pressure;

   modport source (output valid, output drive_correction, output sample_taken,
                   output start_request, output active, output hovering,
                   output rel_pressure, input ready);
   modport sink (input valid, input drive_correction, input sample_taken,
                 input start_request, input active, input hovering,
                 input rel_pressure, output ready);
endinterface

>>> hw/rtl/bahc_csr.sv
module bahc_csr import bahc_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   output cfg_type               cfg,
   output logic                  present_wr
);

   cfg_type    cfg_ff, cfg_in;
   logic       wr_en;
   logic [2:0] reg_idx;

   assign pready  = 1'b1;
   assign wr_en   = psel & penable & pwrite;
   assign reg_idx = paddr[4:2];

   always_comb begin
      cfg_in     = cfg_ff;
      present_wr = 1'b0;
      if (wr_en) begin
         case (reg_idx)
            REG_BARO_PRESENT: begin
               cfg_in.baro_present = pwdata[0];
               present_wr          = 1'b1;
            end
            REG_TEMP_COEFF:  cfg_in.temp_coeff  = pwdata[7:0];
            REG_PROP_GAIN:   cfg_in.prop_gain   = pwdata[6:0];
            REG_DIFF_GAIN:   cfg_in.diff_gain   = pwdata[7:0];
            REG_HARD_FILTER: cfg_in.hard_filter = pwdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      prdata = '0;
      case (reg_idx)
         REG_BARO_PRESENT: prdata[0]   = cfg_ff.baro_present;
         REG_TEMP_COEFF:   prdata[7:0] = cfg_ff.temp_coeff;
         REG_PROP_GAIN:    prdata[6:0] = cfg_ff.prop_gain;
         REG_DIFF_GAIN:    prdata[7:0] = cfg_ff.diff_gain;
         REG_HARD_FILTER:  prdata[0]   = cfg_ff.hard_filter;
         default:          prdata      = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

>>> hw/rtl/bahc_ctrl.sv
module bahc_ctrl import bahc_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   input  sts_type sts,
   output cmd_type cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      req_ready    = 1'b0;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_in = 1'b1;
               state_in    = ST_EVAL;
            end
         end
         ST_EVAL: begin
            cmd.eval = 1'b1;
            state_in = sts.hold_go ? ST_HOLD1 : ST_DONE;
         end
         ST_HOLD1: begin
            cmd.hold1 = 1'b1;
            state_in  = ST_HOLD2;
         end
         ST_HOLD2: begin
            cmd.hold2 = 1'b1;
            state_in  = ST_HOLD3;
         end
         ST_HOLD3: begin
            cmd.hold3 = 1'b1;
            state_in  = ST_HOLD4;
         end
         ST_HOLD4: begin
            cmd.hold4 = 1'b1;
            state_in  = ST_HOLD5;
         end
         ST_HOLD5: begin
            cmd.hold5 = 1'b1;
            state_in  = ST_HOLD6;
         end
         ST_HOLD6: begin
            cmd.hold6 = 1'b1;
            state_in  = ST_DONE;
         end
         ST_DONE: begin
            // The output register is free once its word leaves this cycle.
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_rsp = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

>>> hw/rtl/bahc_dp.sv
module bahc_dp import bahc_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  cmd_type           cmd,
   output sts_type           sts,
   input  cfg_type           cfg,
   input  logic              present_wr,
   input  logic [15:0]       in_sample,
   input  logic              in_read_ok,
   input  logic              in_start_ok,
   input  logic              in_moving,
   output logic signed [4:0] out_drive,
   output logic              out_taken,
   output logic [1:0]        out_request,
   output logic              out_active,
   output logic              out_hovering,
   output logic signed [4:0] out_rel
);

   // Loop state.
   logic [7:0]         tick_ff, tick_in;
   logic               temp_run_ff, temp_run_in;
   logic               alive_ff, alive_in;
   logic signed [15:0] base_temp_ff, base_temp_in;
   logic signed [15:0] base_press_ff, base_press_in;
   logic signed [15:0] temp_corr_ff, temp_corr_in;
   logic signed [4:0]  filt_ff, filt_in;
   logic               hold_ff, hold_in;
   logic signed [4:0]  drive_ff, drive_in;

   // Word and working registers.
   logic [15:0]        sample_ff;
   logic               read_ok_ff, start_ok_ff, moving_ff;
   logic               taken_ff, taken_in;
   logic [1:0]         request_ff, request_in;
   logic signed [4:0]  old_ff;
   logic signed [15:0] x1_ff, prod_ff, x2_ff, num_ff;
   logic signed [4:0]  delta_ff;
   logic signed [7:0]  target_ff, dterm_ff;

   // Output word.
   logic signed [4:0]  rsp_drive_ff, rsp_rel_ff;
   logic               rsp_taken_ff, rsp_active_ff, rsp_hover_ff;
   logic [1:0]         rsp_request_ff;

   logic [7:0]         tick_next;
   logic               due;
   logic signed [4:0]  old_sel;
   logic signed [23:0] corr_prod;
   logic signed [15:0] x1_calc;
   logic signed [15:0] comp_rnd, comp_adj, comp_div, x2_calc;
   logic signed [15:0] old16, old_k, num_calc;
   logic signed [15:0] num_adj, fnew, dlt;
   logic signed [12:0] tgt_prod, dt_prod;
   logic signed [7:0]  d0, d1, d2, dsum;

   function automatic logic signed [7:0] slew(input logic signed [7:0] v,
                                              input logic signed [7:0] t);
      logic signed [7:0] r;
      r = v;
      if (v > t) begin
         r = v - 8'sd1;
      end else if (v < t) begin
         r = v + 8'sd1;
      end
      return r;
   endfunction

   assign tick_next   = tick_ff + 8'd1;
   assign due         = cfg.baro_present & alive_ff &
                        (temp_run_ff ? (tick_next >= TEMP_TICKS) : (tick_next >= PRESS_TICKS));
   assign sts.hold_go = due & read_ok_ff & ~temp_run_ff & ~moving_ff;

   // First hold step: raw offset and the temperature product.
   assign old_sel   = hold_ff ? filt_ff : 5'sd0;
   assign corr_prod = temp_corr_ff * cfg.temp_coeff;
   assign x1_calc   = $signed(sample_ff) - base_press_ff;

   // Second step: rounded divide by 32 that truncates toward zero.
   assign comp_rnd = prod_ff + COMP_ROUND;
   assign comp_adj = comp_rnd[15] ? comp_rnd + 16'sd31 : comp_rnd;
   assign comp_div = comp_adj >>> COMP_SHIFT;
   assign x2_calc  = x1_ff + comp_div;

   // Third step: weighted old value plus sample plus rounding.
   assign old16    = {{11{old_ff[4]}}, old_ff};
   assign old_k    = cfg.hard_filter ? (old16 <<< 3) - old16 : (old16 <<< 1) + old16;
   assign num_calc = old_k + x2_ff + (cfg.hard_filter ? 16'sd4 : 16'sd2);

   // Fourth step: divide by 8 or 4 toward zero, then the change since last update.
   always_comb begin
      if (cfg.hard_filter) begin
         num_adj = num_ff[15] ? num_ff + 16'sd7 : num_ff;
         fnew    = num_adj >>> 3;
      end else begin
         num_adj = num_ff[15] ? num_ff + 16'sd3 : num_ff;
         fnew    = num_adj >>> 2;
      end
   end
   assign dlt = fnew - old16;

   // Fifth step: both loop products, wrapped to eight bits.
   assign tgt_prod = filt_ff * $signed({1'b0, cfg.prop_gain});
   assign dt_prod  = delta_ff * cfg.diff_gain;

   // Sixth step: two slew steps toward the target, derivative term, final clamp.
   assign d0   = {{3{drive_ff[4]}}, drive_ff};
   assign d1   = slew(d0, target_ff);
   assign d2   = slew(d1, target_ff);
   assign dsum = d2 + dterm_ff;

   always_comb begin
      tick_in       = tick_ff;
      temp_run_in   = temp_run_ff;
      alive_in      = alive_ff;
      base_temp_in  = base_temp_ff;
      base_press_in = base_press_ff;
      temp_corr_in  = temp_corr_ff;
      filt_in       = filt_ff;
      hold_in       = hold_ff;
      drive_in      = drive_ff;
      taken_in      = taken_ff;
      request_in    = request_ff;
      if (present_wr) begin
         alive_in = 1'b1;
      end
      if (cmd.eval) begin
         tick_in    = due ? 8'd0 : tick_next;
         taken_in   = due & read_ok_ff;
         request_in = START_NONE;
         if (due) begin
            if (!read_ok_ff) begin
               alive_in = 1'b0;
            end else begin
               if (start_ok_ff) begin
                  temp_run_in = ~temp_run_ff;
               end
               if (temp_run_ff) begin
                  request_in = START_PRESS;
                  if (moving_ff) begin
                     base_temp_in = $signed(sample_ff);
                  end else begin
                     temp_corr_in = $signed(sample_ff) - base_temp_ff;
                  end
               end else begin
                  request_in = START_TEMP;
                  if (moving_ff) begin
                     base_press_in = $signed(sample_ff);
                     hold_in       = 1'b0;
                     drive_in      = 5'sd0;
                  end
               end
            end
         end
      end
      if (cmd.hold1) begin
         hold_in = 1'b1;
      end
      if (cmd.hold4) begin
         if (fnew > REL_MAX) begin
            filt_in = 5'(REL_MAX);
         end else if (fnew < REL_MIN) begin
            filt_in = 5'(REL_MIN);
         end else begin
            filt_in = fnew[4:0];
         end
      end
      if (cmd.hold6) begin
         if (dsum > DRIVE_MAX) begin
            drive_in = 5'(DRIVE_MAX);
         end else if (dsum < DRIVE_MIN) begin
            drive_in = 5'(DRIVE_MIN);
         end else begin
            drive_in = dsum[4:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ff       <= '0;
         temp_run_ff   <= 1'b1;
         alive_ff      <= 1'b1;
         base_temp_ff  <= '0;
         base_press_ff <= '0;
         temp_corr_ff  <= '0;
         filt_ff       <= '0;
         hold_ff       <= 1'b0;
         drive_ff      <= '0;
      end else begin
         tick_ff       <= tick_in;
         temp_run_ff   <= temp_run_in;
         alive_ff      <= alive_in;
         base_temp_ff  <= base_temp_in;
         base_press_ff <= base_press_in;
         temp_corr_ff  <= temp_corr_in;
         filt_ff       <= filt_in;
         hold_ff       <= hold_in;
         drive_ff      <= drive_in;
      end
   end

   always_ff @(posedge clock) begin
      taken_ff   <= taken_in;
      request_ff <= request_in;
      if (cmd.load_in) begin
         sample_ff   <= in_sample;
         read_ok_ff  <= in_read_ok;
         start_ok_ff <= in_start_ok;
         moving_ff   <= in_moving;
      end
      if (cmd.hold1) begin
         old_ff  <= old_sel;
         x1_ff   <= x1_calc;
         prod_ff <= corr_prod[15:0];
      end
      if (cmd.hold2) begin
         x2_ff <= x2_calc;
      end
      if (cmd.hold3) begin
         num_ff <= num_calc;
      end
      if (cmd.hold4) begin
         if (dlt > DELTA_MAX) begin
            delta_ff <= 5'(DELTA_MAX);
         end else if (dlt < DELTA_MIN) begin
            delta_ff <= 5'(DELTA_MIN);
         end else begin
            delta_ff <= dlt[4:0];
         end
      end
      if (cmd.hold5) begin
         target_ff <= tgt_prod[7:0];
         dterm_ff  <= dt_prod[7:0];
      end
      if (cmd.load_rsp) begin
         rsp_drive_ff   <= drive_ff;
         rsp_taken_ff   <= taken_ff;
         rsp_request_ff <= request_ff;
         rsp_active_ff  <= cfg.baro_present & alive_ff;
         rsp_hover_ff   <= hold_ff;
         rsp_rel_ff     <= filt_ff;
      end
   end

   assign out_drive    = rsp_drive_ff;
   assign out_taken    = rsp_taken_ff;
   assign out_request  = rsp_request_ff;
   assign out_active   = rsp_active_ff;
   assign out_hovering = rsp_hover_ff;
   assign out_rel      = rsp_rel_ff;

endmodule

>>> hw/rtl/baro_altitude_hold_compensator_top.sv
// Barometric altitude-hold compensator. Each word on req_bus is one flight-loop tick
// carrying the converter sample and the read, start and throttle flags; each tick yields
// exactly one word on rsp_bus with the drive correction, the sample and start handshake
// toward the sensor, and the loop status. A tick that does not run the hold loop passes
// through the evaluate and done states to the result register; a tick that runs the
// hold loop also passes through the six steps of the shared datapath between them
// (offset and temperature product, rounding, filter sum, filter divide and clamp, the two
// loop products, slew and clamp). A result that still waits on rsp_bus holds the last
// step until it leaves. One tick is in work at a time, and the next is accepted while
// the previous result still waits on rsp_bus. Registers are to be written over the APB
// port only while no tick is in work, by the user; the block does not enforce it.
module baro_altitude_hold_compensator_top import bahc_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   bahc_req_if.sink              req_bus,
   bahc_rsp_if.source            rsp_bus,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   cfg_type cfg;
   cmd_type cmd;
   sts_type sts;
   logic    present_wr;

   bahc_csr u_csr (
      .clock      (clock),
      .reset      (reset),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .prdata     (prdata),
      .pready     (pready),
      .cfg        (cfg),
      .present_wr (present_wr)
   );

   bahc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   bahc_dp u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .sts          (sts),
      .cfg          (cfg),
      .present_wr   (present_wr),
      .in_sample    (req_bus.sample),
      .in_read_ok   (req_bus.read_ok),
      .in_start_ok  (req_bus.start_ok),
      .in_moving    (req_bus.throttle_moving),
      .out_drive    (rsp_bus.drive_correction),
      .out_taken    (rsp_bus.sample_taken),
      .out_request  (rsp_bus.start_request),
      .out_active   (rsp_bus.active),
      .out_hovering (rsp_bus.hovering),
      .out_rel      (rsp_bus.rel_pressure)
   );

endmodule

>>> hw/rtl/bahc_checker.sv
module bahc_checker import bahc_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic signed [4:0] rsp_drive,
   input logic              rsp_taken,
   input logic [1:0]        rsp_request,
   input logic              rsp_active,
   input logic signed [4:0] rsp_rel
);

   // A stalled result word keeps its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_drive) && $stable(rsp_rel)
         && $stable(rsp_taken) && $stable(rsp_request))
      else $error("result word changed while stalled");

   // One tick is in work at a time.
   a_one_tick: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second tick accepted while one is in work");

   a_drive_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_drive >= -5 && rsp_drive <= 15)
      else $error("drive correction out of range");

   a_rel_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_rel >= -3 && rsp_rel <= 8)
      else $error("relative pressure out of range");

   // A start is requested exactly when a sample is consumed, which needs an active block.
   a_taken_request: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_taken ? (rsp_active && (rsp_request == START_TEMP
         || rsp_request == START_PRESS)) : (rsp_request == START_NONE)))
      else $error("sample handshake inconsistent");

endmodule

bind baro_altitude_hold_compensator_top bahc_checker u_bahc_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_bus.valid),
   .req_ready   (req_bus.ready),
   .rsp_valid   (rsp_bus.valid),
   .rsp_ready   (rsp_bus.ready),
   .rsp_drive   (rsp_bus.drive_correction),
   .rsp_taken   (rsp_bus.sample_taken),
   .rsp_request (rsp_bus.start_request),
   .rsp_active  (rsp_bus.active),
   .rsp_rel     (rsp_bus.rel_pressure)
);

>>> tb/sv/testbench.sv
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import bahc_pkg::*;

   localparam int STUCK_LIMIT = 2000;
   localparam int PRINT_LIMIT = 40;

   typedef struct packed {
      logic [15:0] sample;
      logic        read_ok;
      logic        start_ok;
      logic        throttle_moving;
   } tick_word_type;

   typedef struct packed {
      logic signed [4:0] drive_correction;
      logic              sample_taken;
      logic [1:0]        start_request;
      logic              active;
      logic              hovering;
      logic signed [4:0] rel_pressure;
   } status_word_type;

   typedef enum logic {ROW_TICK, ROW_WRITE} row_kind_type;

   typedef struct packed {
      row_kind_type    kind;
      logic [2:0]      reg_idx;
      logic [7:0]      wr_data;
      logic [5:0]      reps;
      tick_word_type   word;
      logic            typed;
      status_word_type want;
   } plan_row_type;

   // Tick flags are {read_ok, start_ok, throttle_moving}; status words are
   // {drive, taken, start request, active, hovering, relative pressure}.
   localparam plan_row_type DIRECTED [24] = '{
      '{ROW_TICK,  REG_BARO_PRESENT, 8'h00, 6'd1,  {16'h0000, 3'b110}, 1'b1,
        {5'd0, 1'b0, START_NONE, 1'b0, 1'b0, 5'd0}},
      '{ROW_WRITE, REG_BARO_PRESENT, 8'h01, 6'd0,  19'd0, 1'b0, 15'd0},
      '{ROW_TICK,  REG_BARO_PRESENT, 8'h00, 6'd1,  {16'hFFFF, 3'b111}, 1'b1,
        {5'd0, 1'b1, START_PRESS, 1'b1, 1'b0, 5'd0}},
      '{ROW_TICK,  REG_BARO_PRESENT, 8'h00, 6'd7,  {16'h0000, 3'b000}, 1'b0, 15'd0},
      '{ROW_TICK,  REG_BARO_PRESENT, 8'h00, 6'd1,  {16'h1234, 3'b111}, 1'b1,
        {5'd0, 1'b1, START_TEMP, 1'b1, 1'b0, 5'd0}},
      '{ROW_WRITE, REG_TEMP_COEFF,   8'h80, 6'd0,  19'd0, 1'b0, 15'd0},
      '{ROW_WRITE, REG_PROP_GAIN,    8'h7F, 6'd0,  19'd0, 1'b0, 15'd0},
      '{ROW_WRITE, REG_DIFF_GAIN,    8'h7F, 6'd0,  19'd0, 1'b0, 15'd0},
      '{ROW_WRITE, REG_HARD_FILTER,  8'h01, 6'd0,  19'd0, 1'b0, 15'd0},
      '{ROW_TICK,  REG_BARO_PRESENT, 8'h00, 6'd2,  {16'h0010, 3'b110}, 1'b0, 15'd0},
      '{ROW_TICK,  REG_BARO_PRESENT, 8'h00, 6'd8,  {16'h1240, 3'b110}, 1'b0, 15'd0},
      '{ROW_TICK,  REG_BARO_PRESENT, 8'h00, 6'd2,  {16'h8000, 3'b100}, 1'b0, 15'd0},
      '{ROW_TICK,  REG_BARO_PRESENT, 8'h00, 6'd2,  {16'h7FFF, 3'b110}, 1'b0, 15'd0},
      '{ROW_TICK,  REG_BARO_PRESENT, 8'h00, 6'd8,  {16'h0000, 3'b110}, 1'b0, 15'd0},
      '{ROW_TICK,  REG_BARO_PRESENT, 8'h00, 6'd2,  {16'h1236, 3'b010}, 1'b0, 15'd0},
      '{ROW_TICK,  REG_BARO_PRESENT, 8'h00, 6'd1,  {16'h1236, 3'b110}, 1'b0, 15'd0},
      '{ROW_WRITE, REG_BARO_PRESENT, 8'h01, 6'd0,  19'd0, 1'b0, 15'd0},
      '{ROW_WRITE, REG_HARD_FILTER,  8'h00, 6'd0,  19'd0, 1'b0, 15'd0},
      '{ROW_WRITE, REG_DIFF_GAIN,    8'h80, 6'd0,  19'd0, 1'b0, 15'd0},
      '{ROW_WRITE, REG_PROP_GAIN,    8'h00, 6'd0,  19'd0, 1'b0, 15'd0},
      '{ROW_WRITE, REG_TEMP_COEFF,   8'h7F, 6'd0,  19'd0, 1'b0, 15'd0},
      '{ROW_TICK,  REG_BARO_PRESENT, 8'h00, 6'd10, {16'h1230, 3'b110}, 1'b0, 15'd0},
      '{ROW_WRITE, REG_BARO_PRESENT, 8'h00, 6'd0,  19'd0, 1'b0, 15'd0},
      '{ROW_TICK,  REG_BARO_PRESENT, 8'h00, 6'd1,  {16'hFFFF, 3'b111}, 1'b0, 15'd0}
   };

   logic                  clock;
   logic                  reset;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   bahc_req_if req_bus();
   bahc_rsp_if rsp_bus();

   baro_altitude_hold_compensator_top i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   // Predicted state of the compensator.
   cfg_type     cfg         = '0;
   logic [7:0]  tick_cnt    = 8'd0;
   logic        temp_phase  = 1'b1;
   logic        link_up     = 1'b1;
   logic        hold_on     = 1'b0;
   int          base_t      = 0;
   int          base_p      = 0;
   int          t_corr      = 0;
   int          filt_p      = 0;
   int          drive_v     = 0;

   status_word_type expected_status_q[$];
   status_word_type last_status;
   status_word_type oldest;

   int idle_pct     = 0;
   int stall_pct    = 0;
   int moving_left  = 0;
   int error_count  = 0;
   int stuck_cycles = 0;
   int n_ticks      = 0;
   int n_taken      = 0;
   int n_holds      = 0;
   int n_failed     = 0;
   int n_writes     = 0;

   function automatic int w16(input int v);
      logic signed [15:0] t;
      t = v[15:0];
      return t;
   endfunction

   function automatic int w8(input int v);
      logic signed [7:0] t;
      t = v[7:0];
      return t;
   endfunction

   function automatic void hold_loop_update(input int raw);
      int x, comp, old, delta, target, k, r, d;
      n_holds++;
      if (!hold_on) begin
         filt_p  = 0;
         hold_on = 1'b1;
      end
      x    = w16(raw - base_p);
      comp = w16(t_corr * w8(int'(cfg.temp_coeff)));
      comp = w16(comp + 16) / 32;
      x    = w16(x + comp);

      old = filt_p;
      if (cfg.hard_filter) begin
         k = 7; r = 4; d = 8;
      end else begin
         k = 3; r = 2; d = 4;
      end
      filt_p = w16(old * k + x + r) / d;
      delta  = w16(filt_p - old);

      if (filt_p > 8) filt_p = 8;
      else if (filt_p < -3) filt_p = -3;

      // The slew moves the drive at most two steps toward the target per update.
      target = w8(filt_p * int'(cfg.prop_gain));
      repeat (2) begin
         if (drive_v > target) drive_v--;
         else if (drive_v < target) drive_v++;
      end

      if (delta > 8) delta = 8;
      else if (delta < -8) delta = -8;
      drive_v = w8(drive_v + w8(delta * w8(int'(cfg.diff_gain))));

      if (drive_v > 15) drive_v = 15;
      else if (drive_v < -5) drive_v = -5;
   endfunction

   function automatic status_word_type predict_tick(input tick_word_type w);
      status_word_type s;
      logic            on;
      int              smp;
      s        = '0;
      smp      = w16(int'(w.sample));
      on       = cfg.baro_present && link_up;
      tick_cnt = tick_cnt + 8'd1;
      n_ticks++;
      if (on && ((temp_phase && tick_cnt >= TEMP_TICKS) ||
                 (!temp_phase && tick_cnt >= PRESS_TICKS))) begin
         tick_cnt = 8'd0;
         if (!w.read_ok) begin
            link_up = 1'b0;
            n_failed++;
         end else begin
            s.sample_taken = 1'b1;
            n_taken++;
            if (temp_phase) begin
               s.start_request = START_PRESS;
               if (w.start_ok) temp_phase = 1'b0;
               if (w.throttle_moving) base_t = smp;
               else t_corr = w16(smp - base_t);
            end else begin
               s.start_request = START_TEMP;
               if (w.start_ok) temp_phase = 1'b1;
               if (w.throttle_moving) begin
                  base_p  = smp;
                  hold_on = 1'b0;
                  drive_v = 0;
               end else begin
                  hold_loop_update(smp);
               end
            end
         end
      end
      s.drive_correction = drive_v[4:0];
      s.active           = cfg.baro_present && link_up;
      s.hovering         = hold_on;
      s.rel_pressure     = filt_p[4:0];
      return s;
   endfunction

   // Mostly samples close to the current base so that the hold loop stays in
   // its interesting range; throttle moves come in short bursts.
   function automatic tick_word_type random_tick();
      tick_word_type w;
      int            base, span;
      if (moving_left > 0) moving_left--;
      else if ($urandom_range(99) < 3) moving_left = $urandom_range(12, 1);
      w.throttle_moving = (moving_left > 0);
      w.read_ok         = ($urandom_range(199) != 0);
      w.start_ok        = ($urandom_range(99) >= 10);
      base = temp_phase ? base_t : base_p;
      span = temp_phase ? 12 : 40;
      if (w.throttle_moving || $urandom_range(99) < 5)
         w.sample = 16'($urandom);
      else
         w.sample = 16'(base + int'($urandom_range(2 * span)) - span);
      return w;
   endfunction

   task automatic report_mismatch(input string what);
      error_count++;
      if (error_count <= PRINT_LIMIT) $display("[%0t] MISMATCH: %s", $realtime, what);
   endtask

   task automatic check_field(input string name, input logic signed [31:0] got,
                              input logic signed [31:0] want);
      if (got !== want) report_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
   endtask

   task automatic send_tick(input tick_word_type w, input logic typed,
                            input status_word_type want);
      if ($urandom_range(99) < idle_pct) begin
         req_bus.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < idle_pct);
      end
      req_bus.valid           <= 1'b1;
      req_bus.sample          <= w.sample;
      req_bus.read_ok         <= w.read_ok;
      req_bus.start_ok        <= w.start_ok;
      req_bus.throttle_moving <= w.throttle_moving;
      do @(posedge clock); while (!req_bus.ready);
      last_status = predict_tick(w);
      expected_status_q.push_back(typed ? want : last_status);
   endtask

   // Registers change only while no word is in flight.
   task automatic settle();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (expected_status_q.size() != 0);
      repeat (12) @(posedge clock);
   endtask

   task automatic csr_write(input logic [2:0] idx, input logic [31:0] data);
      logic [31:0] got, want, mask;
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      n_writes++;
      case (idx)
         REG_BARO_PRESENT: begin
            cfg.baro_present = data[0];
            link_up          = 1'b1;
         end
         REG_TEMP_COEFF:  cfg.temp_coeff  = data[7:0];
         REG_PROP_GAIN:   cfg.prop_gain   = data[6:0];
         REG_DIFF_GAIN:   cfg.diff_gain   = data[7:0];
         REG_HARD_FILTER: cfg.hard_filter = data[0];
         default: ;
      endcase

      // Read the register straight back.
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      got = prdata;
      psel    <= 1'b0;
      penable <= 1'b0;
      case (idx)
         REG_BARO_PRESENT: begin mask = 32'h1;  want = 32'(cfg.baro_present); end
         REG_TEMP_COEFF:   begin mask = 32'hFF; want = 32'(cfg.temp_coeff[7:0]); end
         REG_PROP_GAIN:    begin mask = 32'h7F; want = 32'(cfg.prop_gain); end
         REG_DIFF_GAIN:    begin mask = 32'hFF; want = 32'(cfg.diff_gain[7:0]); end
         default:          begin mask = 32'h1;  want = 32'(cfg.hard_filter); end
      endcase
      if ((got & mask) !== want)
         report_mismatch($sformatf("register %0d reads 0x%0h, expected 0x%0h",
                                   idx, got & mask, want));
      @(posedge clock);
   endtask

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_status_q.size() == 0) begin
               report_mismatch("status word arrived with none expected");
            end else begin
               oldest = expected_status_q.pop_front();
               check_field("drive_correction", rsp_bus.drive_correction,
                           oldest.drive_correction);
               check_field("sample_taken", {1'b0, rsp_bus.sample_taken},
                           {1'b0, oldest.sample_taken});
               check_field("start_request", {1'b0, rsp_bus.start_request},
                           {1'b0, oldest.start_request});
               check_field("active", {1'b0, rsp_bus.active}, {1'b0, oldest.active});
               check_field("hovering", {1'b0, rsp_bus.hovering}, {1'b0, oldest.hovering});
               check_field("rel_pressure", rsp_bus.rel_pressure, oldest.rel_pressure);
            end
         end
         rsp_bus.ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || psel || (req_bus.valid && req_bus.ready) ||
          (rsp_bus.valid && rsp_bus.ready)) begin
         stuck_cycles <= 0;
      end else if (stuck_cycles >= STUCK_LIMIT) begin
         $display("Timeout: nothing moved for %0d cycles, %0d words outstanding",
                  STUCK_LIMIT, expected_status_q.size());
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
      end
   end

   initial begin
      int          phase, n, park_len, taken_here;
      logic [7:0]  coeff, diffg;
      logic [6:0]  prop;
      logic        hard;

      reset                   <= 1'b1;
      psel                    <= 1'b0;
      penable                 <= 1'b0;
      pwrite                  <= 1'b0;
      paddr                   <= '0;
      pwdata                  <= '0;
      req_bus.valid           <= 1'b0;
      req_bus.sample          <= '0;
      req_bus.read_ok         <= 1'b0;
      req_bus.start_ok        <= 1'b0;
      req_bus.throttle_moving <= 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      foreach (DIRECTED[i]) begin
         if (DIRECTED[i].kind == ROW_WRITE) begin
            settle();
            csr_write(DIRECTED[i].reg_idx, 32'(DIRECTED[i].wr_data));
         end else begin
            for (n = 0; n < DIRECTED[i].reps; n++)
               send_tick(DIRECTED[i].word, DIRECTED[i].typed, DIRECTED[i].want);
         end
      end

      for (phase = 0; phase < 8; phase++) begin
         settle();
         if (phase == 4) begin
            // Parked block: the tick counter free-runs past its wrap.
            csr_write(REG_BARO_PRESENT, 32'd0);
            idle_pct  = 0;
            stall_pct = 0;
            park_len  = 256 + $urandom_range(16);
            for (n = 0; n < park_len; n++) send_tick(random_tick(), 1'b0, '0);
            settle();
         end
         case (phase)
            0: begin coeff = 8'h7F; prop = 7'h7F; diffg = 8'h7F; hard = 1'b1; end
            1: begin coeff = 8'h80; prop = 7'h00; diffg = 8'h80; hard = 1'b0; end
            2: begin coeff = 8'h00; prop = 7'h01; diffg = 8'h01; hard = 1'b1; end
            default: begin
               coeff = 8'($urandom);
               prop  = 7'($urandom);
               diffg = 8'($urandom);
               hard  = 1'($urandom);
            end
         endcase
         csr_write(REG_BARO_PRESENT, 32'd1);
         csr_write(REG_TEMP_COEFF, 32'(coeff));
         csr_write(REG_PROP_GAIN, 32'(prop));
         csr_write(REG_DIFF_GAIN, 32'(diffg));
         csr_write(REG_HARD_FILTER, 32'(hard));
         case (phase % 4)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 83; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 83; end
            default: begin idle_pct = 7; stall_pct = 7; end
         endcase

         taken_here = 0;
         while (taken_here < 5) begin
            send_tick(random_tick(), 1'b0, '0);
            if (last_status.sample_taken || !link_up) taken_here++;
            // A failed read parks the block until the presence bit is written again.
            if (cfg.baro_present && !link_up) begin
               settle();
               csr_write(REG_BARO_PRESENT, 32'd1);
            end
         end
      end

      req_bus.valid <= 1'b0;
      do @(posedge clock); while (expected_status_q.size() != 0);
      repeat (20) @(posedge clock);

      $display("Covered %0d ticks: %0d samples taken, %0d hold-loop updates, %0d failed reads,",
               n_ticks, n_taken, n_holds, n_failed);
      $display("and %0d register writes across eight settings and four idle patterns.",
               n_writes);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

>>> files.f
hw/rtl/bahc_pkg.sv
hw/rtl/bahc_if.sv
hw/rtl/bahc_csr.sv
hw/rtl/bahc_ctrl.sv
hw/rtl/bahc_dp.sv
hw/rtl/baro_altitude_hold_compensator_top.sv
hw/rtl/bahc_checker.sv
tb/sv/testbench.sv
